// File: rtl/core/u2d_pkg.sv
package u2d_pkg;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_MARK   = 8'h80;
	localparam logic [7:0] LEAD_MASK   = 8'hE0;
	localparam logic [7:0] LEAD3_MARK  = 8'hE0;
	localparam logic [7:0] LEAD2_MARK  = 8'hC0;
	localparam logic [7:0] LOW4_MASK   = 8'h0F;
	localparam logic [7:0] LOW5_MASK   = 8'h1F;
	localparam logic [7:0] LOW6_MASK   = 8'h3F;

	localparam int MAX_UNITS = 3;

	// One decoded step: up to three code units, how many are valid, and
	// whether the step closes the text.
	typedef struct packed {
		logic [MAX_UNITS-1:0][15:0] units;
		logic [1:0]                 cnt;
		logic                       last;
	} step_t;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_MARK;
	endfunction

endpackage

// File: rtl/core/utf8_to_ucs2_decode.sv
// Channel  Handshake            Payload                  Beat
// in       in_valid/in_ready    text_byte, final_byte    one UTF-8 byte
// out      out_valid/out_ready  code_unit, text_done     one 16-bit code unit
//
// One byte is taken per cycle while the step queue has room; a byte that
// closes a sequence puts its step in the queue, and out shows it from there.
// A byte whose step yields two or three units holds the back end for that
// many beats; the QDEPTH-entry step queue absorbs it, so in stalls only
// when the queue fills. Bytes that only open a sequence take no queue slot.
// Reset (arst_n low) empties the holder and the queue at once.
module utf8_to_ucs2_decode import u2d_pkg::*; #(
	parameter int QDEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        text_done
);

	logic  push;
	step_t push_step;
	logic  q_full;
	logic  head_valid;
	step_t head_step;
	logic  pop;

	// Front: hold open sequences and resolve each byte into a step.
	u2d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.push       (push),
		.push_step  (push_step),
		.q_full     (q_full)
	);

	// Queue: decouple byte intake from unit delivery.
	u2d_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_step  (push_step),
		.full       (q_full),
		.head_valid (head_valid),
		.head_step  (head_step),
		.pop        (pop)
	);

	// Back: serialize each step into code-unit beats.
	u2d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_step  (head_step),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_unit  (code_unit),
		.text_done  (text_done)
	);

endmodule

// File: rtl/core/u2d_front.sv
module u2d_front import u2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output logic       push,
	output step_t      push_step,
	input  logic       q_full
);

	logic [1:0][7:0] held_q;
	logic [1:0]      held_count_q;

	logic [2:0][7:0] buf_b;
	logic [1:0]      n_b;
	logic [1:0]      pos;
	logic [1:0]      cnt;
	logic [1:0]      nxt_count;
	logic [1:0][7:0] nxt_held;
	logic            accept;

	function automatic logic [7:0] pick(input logic [2:0][7:0] b, input logic [2:0] idx);
		return (idx < 3'd3) ? b[idx[1:0]] : 8'h00;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Line up held bytes ahead of the new one.
	always_comb begin
		buf_b = '0;
		unique case (held_count_q)
			2'd0: begin
				buf_b[0] = text_byte;
			end
			2'd1: begin
				buf_b[0] = held_q[0];
				buf_b[1] = text_byte;
			end
			default: begin
				buf_b[0] = held_q[0];
				buf_b[1] = held_q[1];
				buf_b[2] = text_byte;
			end
		endcase
		n_b = (held_count_q >= 2'd2) ? 2'd3 : held_count_q + 2'd1;
	end

	// Resolve the buffer left to right; each pass takes at least one byte or stops.
	always_comb begin
		logic        stop;
		logic        emit;
		logic [15:0] val;
		logic [1:0]  step;
		logic [1:0]  avail;
		logic [7:0]  c0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		pos       = 2'd0;
		cnt       = 2'd0;
		stop      = 1'b0;
		push_step = '0;
		for (int it = 0; it < MAX_UNITS; it++) begin
			emit  = 1'b0;
			val   = 16'h0000;
			step  = 2'd0;
			avail = n_b - pos;
			c0    = pick(buf_b, {1'b0, pos});
			b1    = pick(buf_b, {1'b0, pos} + 3'd1);
			b2    = pick(buf_b, {1'b0, pos} + 3'd2);
			if (!stop && pos < n_b) begin
				priority if (c0 < ASCII_LIMIT) begin
					emit = 1'b1;
					val  = {8'h00, c0};
					step = 2'd1;
				end else if ((c0 & LEAD_MASK) == LEAD3_MARK) begin
					priority if (avail >= 2'd2 && !is_cont(b1)) begin
						emit = 1'b1;
						val  = {8'h00, c0};
						step = 2'd1;
					end else if (avail == 2'd3) begin
						emit = 1'b1;
						if (is_cont(b2)) begin
							val  = {c0[3:0] & LOW4_MASK[3:0], b1[5:0] & LOW6_MASK[5:0],
								b2[5:0] & LOW6_MASK[5:0]};
							step = 2'd3;
						end else begin
							val  = {8'h00, c0};
							step = 2'd1;
						end
					end else if (final_byte) begin
						emit = 1'b1;
						val  = {8'h00, c0};
						step = 2'd1;
					end else begin
						stop = 1'b1;
					end
				end else if ((c0 & LEAD_MASK) == LEAD2_MARK) begin
					priority if (avail >= 2'd2) begin
						emit = 1'b1;
						if (is_cont(b1)) begin
							val  = {5'b00000, c0[4:0] & LOW5_MASK[4:0],
								b1[5:0] & LOW6_MASK[5:0]};
							step = 2'd2;
						end else begin
							val  = {8'h00, c0};
							step = 2'd1;
						end
					end else if (final_byte) begin
						emit = 1'b1;
						val  = {8'h00, c0};
						step = 2'd1;
					end else begin
						stop = 1'b1;
					end
				end else begin
					emit = 1'b1;
					val  = {8'h00, c0};
					step = 2'd1;
				end
				if (emit) begin
					push_step.units[cnt] = val;
					cnt = cnt + 2'd1;
				end
				pos = pos + step;
			end
		end
		push_step.cnt  = cnt;
		push_step.last = final_byte;
		nxt_count      = n_b - pos;
		nxt_held[0]    = pick(buf_b, {1'b0, pos});
		nxt_held[1]    = pick(buf_b, {1'b0, pos} + 3'd1);
	end

	// Drop steps that give nothing; they only change the held bytes.
	assign push = accept && (cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
		end else if (accept) begin
			held_count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= nxt_held;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= 2'd2)
		else $error("held byte count above two");

	a_final_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_byte |=> held_count_q == 2'd0)
		else $error("bytes still held after final beat");

endmodule

// File: rtl/core/u2d_queue.sv
module u2d_queue import u2d_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  step_t push_step,
	output logic  full,
	output logic  head_valid,
	output step_t head_step,
	input  logic  pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	step_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = count_q == DEPTH_C;
	assign head_valid = count_q != '0;
	assign head_step  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_step;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("step queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("step queue underflow");

endmodule

// File: rtl/core/u2d_back.sv
module u2d_back import u2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  step_t       head_step,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        text_done
);

	logic [1:0] sub_q;
	logic       last_unit;

	assign last_unit = sub_q == (head_step.cnt - 2'd1);
	assign out_valid = head_valid;
	assign code_unit = head_step.units[sub_q];
	assign text_done = head_step.last && last_unit;
	assign pop       = out_valid && out_ready && last_unit;

	// Advance through the units of the head step, one per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			sub_q <= last_unit ? 2'd0 : sub_q + 2'd1;
		end
	end

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> head_step.cnt != 2'd0 && sub_q < head_step.cnt)
		else $error("unit index outside head step");

endmodule

// File: verif/tb_utf8_to_ucs2_decode.sv
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decode;
	import u2d_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	// Settle time after the last owed unit: the decoder's latency plus queue slack
	localparam int TAIL_CYCLES = 20;

	// One byte waiting to go out on the in channel
	typedef struct {
		logic [7:0] data;
		logic       fin;
		int         gap;    // idle cycles before this beat
		bit         drain;  // hold this beat until every owed unit has come
	} text_beat_t;

	// One code unit the decoder still owes
	typedef struct {
		logic [15:0] code;
		logic        done;
	} owed_unit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h01;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] code_unit;
	logic        text_done;

	text_beat_t tx_bytes[$];
	owed_unit_t owed_units[$];
	owed_unit_t want;

	// Decoder state as the predictor tracks it
	logic [7:0] open_seq[2];
	int         open_len = 0;

	bit tx_calm = 1'b0;
	bit drain_next = 1'b0;
	bit units_drained = 1'b1;
	int gap_left = 0;
	int stall_left = 0;
	int beats_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;

	utf8_to_ucs2_decode DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_unit  (code_unit),
		.text_done  (text_done)
	);

	always #5 clk = ~clk;

	function automatic bit trail_byte(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_MARK;
	endfunction

	// Advance the predicted decoder by one byte and queue the units it owes.
	// Held bytes come first, then the new byte; decode as far as the window
	// allows and hold whatever is still an open sequence.
	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		logic [7:0]  win[3];
		logic [15:0] step_units[$];
		logic [7:0]  lead;
		int          n;
		int          pos;
		int          avail;
		bit          open;
		owed_unit_t  u;

		n = open_len;
		for (int i = 0; i < n; i++)
			win[i] = open_seq[i];
		win[n] = b;
		n++;
		pos = 0;
		open = 1'b0;

		while (pos < n && !open) begin
			avail = n - pos;
			lead = win[pos];
			if (lead < ASCII_LIMIT) begin
				step_units.push_back({8'h00, lead});
				pos++;
			end else if ((lead & LEAD_MASK) == LEAD3_MARK) begin
				// three-byte lead, 0xF0..0xFF included
				if (avail >= 2 && !trail_byte(win[pos+1])) begin
					step_units.push_back({8'h00, lead});
					pos++;
				end else if (avail >= 3) begin
					if (trail_byte(win[pos+2])) begin
						step_units.push_back({lead[3:0], win[pos+1][5:0], win[pos+2][5:0]});
						pos += 3;
					end else begin
						step_units.push_back({8'h00, lead});
						pos++;
					end
				end else if (fin) begin
					step_units.push_back({8'h00, lead});
					pos++;
				end else begin
					open = 1'b1;
				end
			end else if ((lead & LEAD_MASK) == LEAD2_MARK) begin
				if (avail >= 2) begin
					if (trail_byte(win[pos+1])) begin
						step_units.push_back({5'b0, lead[4:0], win[pos+1][5:0]});
						pos += 2;
					end else begin
						step_units.push_back({8'h00, lead});
						pos++;
					end
				end else if (fin) begin
					step_units.push_back({8'h00, lead});
					pos++;
				end else begin
					open = 1'b1;
				end
			end else begin
				// stray continuation byte: pass it through raw
				step_units.push_back({8'h00, lead});
				pos++;
			end
		end

		open_len = n - pos;
		for (int i = 0; i < open_len; i++)
			open_seq[i] = win[pos+i];

		// text_done marks only the last unit of a final step
		foreach (step_units[i]) begin
			u.code = step_units[i];
			u.done = fin && (i == step_units.size() - 1);
			owed_units.push_back(u);
		end
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic fin);
		text_beat_t it;
		it.data = b;
		it.fin = fin;
		it.gap = tx_calm ? 0 : $urandom_range(0, 19);
		it.drain = drain_next;
		drain_next = 1'b0;
		tx_bytes.push_back(it);
	endtask

	function automatic logic [7:0] lead2_byte();
		return {3'b110, 5'($urandom)};
	endfunction

	function automatic logic [7:0] lead3_byte();
		return {3'b111, 5'($urandom)};
	endfunction

	function automatic logic [7:0] trail_rand();
		return {2'b10, 6'($urandom)};
	endfunction

	// A byte that can never continue a sequence: ASCII or a lead byte
	function automatic logic [7:0] plain_byte();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(1, 8'h7F));
		return {2'b11, 6'($urandom)};
	endfunction

	// Driver: present one beat at a time, honor per-beat gaps and drain holds.
	// A beat accepted this edge was predicted from the old owed count, so
	// never release a drain hold on the same edge.
	always @(posedge clk or negedge arst_n) begin
		bit fired;
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= 8'h01;
			final_byte <= 1'b0;
			gap_left = 0;
		end else begin
			fired = in_valid && in_ready;
			if (fired) begin
				decode_byte(text_byte, final_byte);
				if (tx_bytes.size() != 0)
					gap_left = tx_bytes[0].gap;
			end
			if (!in_valid || fired) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tx_bytes.size() != 0 &&
						(!tx_bytes[0].drain || (units_drained && !fired))) begin
					in_valid <= 1'b1;
					text_byte <= tx_bytes[0].data;
					final_byte <= tx_bytes[0].fin;
					void'(tx_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sample the owed count away from the rising edge so the driver sees a
	// settled value.
	always @(negedge clk)
		units_drained <= (owed_units.size() == 0);

	// Monitor: check each out beat against the oldest owed unit, then draw a
	// stall. Every third stretch of 24 beats runs with ready held high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_units.size() == 0) begin
					$error("unexpected beat: code_unit %h text_done %b", code_unit, text_done);
					mismatches++;
				end else begin
					want = owed_units.pop_front();
					if (code_unit !== want.code) begin
						$error("code_unit: expected %h, actual %h", want.code, code_unit);
						mismatches++;
					end
					if (text_done !== want.done) begin
						$error("text_done: expected %b, actual %b", want.done, text_done);
						mismatches++;
					end
				end
				beats_seen++;
				stall_left = ((beats_seen / 24) % 3 == 2) ? 0 : $urandom_range(0, 19);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL utf8_to_ucs2_decode");
			$finish;
		end
	end

	initial begin
		int kind;
		int sub;
		bit fin;
		bit mid_drain_done;

		mid_drain_done = 1'b0;

		// ASCII extremes
		add_byte(8'h01, 1'b0);
		add_byte(8'h7F, 1'b0);
		// two-byte and three-byte sequences, largest unit and a 0xF0..0xFF lead
		add_byte(8'hC2, 1'b0);
		add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'hAC, 1'b0);
		add_byte(8'hEF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0);
		// lone continuation byte passes raw
		add_byte(8'h80, 1'b0);
		// broken sequences: lead followed by a plain byte
		add_byte(8'hC3, 1'b0);
		add_byte(8'h41, 1'b0);
		add_byte(8'hE2, 1'b0);
		add_byte(8'h41, 1'b0);
		// broken at the third byte, closing the text on it
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'h41, 1'b1);
		// final byte flushes an open three-byte and an open two-byte sequence
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b1);
		add_byte(8'hC3, 1'b1);
		// largest two-byte unit on a final byte
		add_byte(8'hDF, 1'b0);
		add_byte(8'hBF, 1'b1);

		// Random part: mostly well-formed sequences, some noise and broken or
		// truncated ones. Hold off the first random beat until the decoder has
		// caught up.
		drain_next = 1'b1;
		while (tx_bytes.size() < 158) begin
			tx_calm = ((tx_bytes.size() / 30) % 3 == 1);
			if (!mid_drain_done && tx_bytes.size() >= 110) begin
				drain_next = 1'b1;
				mid_drain_done = 1'b1;
			end
			kind = $urandom_range(0, 9);
			sub = $urandom_range(0, 2);
			fin = ($urandom_range(0, 9) == 0);
			case (kind)
				0, 1, 2: begin
					add_byte(8'($urandom_range(1, 8'h7F)), fin);
				end
				3, 4: begin
					add_byte(lead2_byte(), 1'b0);
					add_byte(trail_rand(), fin);
				end
				5, 6: begin
					add_byte(lead3_byte(), 1'b0);
					add_byte(trail_rand(), 1'b0);
					add_byte(trail_rand(), fin);
				end
				7: begin
					add_byte(8'($urandom_range(1, 255)), fin);
				end
				8: begin
					if (sub == 0) begin
						add_byte(lead2_byte(), 1'b0);
					end else if (sub == 1) begin
						add_byte(lead3_byte(), 1'b0);
					end else begin
						add_byte(lead3_byte(), 1'b0);
						add_byte(trail_rand(), 1'b0);
					end
					add_byte(plain_byte(), fin);
				end
				default: begin
					// text ends inside an open sequence
					if (sub == 0) begin
						add_byte(lead2_byte(), 1'b1);
					end else if (sub == 1) begin
						add_byte(lead3_byte(), 1'b1);
					end else begin
						add_byte(lead3_byte(), 1'b0);
						add_byte(trail_rand(), 1'b1);
					end
				end
			endcase
		end
		// close the text so nothing stays held
		add_byte(8'($urandom_range(1, 255)), 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() != 0 || in_valid)
			@(negedge clk);
		while (owed_units.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("PASS utf8_to_ucs2_decode");
		end else begin
			$display("FAIL utf8_to_ucs2_decode");
		end
		$finish;
	end

endmodule
